### rtl/fixed_step_frame_timer_unit_macros.svh
`ifndef FIXED_STEP_FRAME_TIMER_UNIT_MACROS_SVH
`define FIXED_STEP_FRAME_TIMER_UNIT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define FSFT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fsft assertion failed");

// Clocked assertion, checked in reset too.
`define FSFT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("fsft assertion failed");

`endif

### rtl/fsft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsft_pkg;

    localparam int unsigned RAW_W   = 27;
    localparam int unsigned STEP_W  = 24;
    localparam int unsigned FREQ_W  = 30;
    localparam int unsigned CNT_W   = 64;
    localparam int unsigned OUT_W   = 176;
    localparam int unsigned CFGD_W  = 30;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_TARGET = 2'd1,
        CFG_FREQ   = 2'd2,
        CFG_MAXRAW = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RESET,
        OP_CAPTURE,
        OP_MUL,
        OP_SCALE,
        OP_STEPS,
        OP_TOTAL,
        OP_FRAME,
        OP_CHECK,
        OP_SACC,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_STEP,
        DIV_SEC
    } t_div_sel;

    typedef struct packed {
        t_op      op;
        logic     div_start;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic fixed;
        logic target_zero;
        logic freq_zero;
        logic sacc_ge;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

### rtl/fsft_div.sv
`timescale 1ns / 1ps
`default_nettype none
module fsft_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    input  wire logic [6:0]  i_len,
    output logic             o_done,
    output logic [63:0]      o_quo,
    output logic [31:0]      o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] n_t;
    logic        n_ge;

    always_comb begin
        n_t  = {r_rem, r_dvd[63]};
        n_ge = n_t >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend << (7'd64 - i_len);
            r_rem <= 32'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], n_ge};
            r_rem <= n_ge ? 32'(n_t - {1'b0, r_div}) : n_t[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

### rtl/fsft_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module fsft_dp #(
    parameter int unsigned TICKS_PER_SECOND = 10000000
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire fsft_pkg::t_cmd         i_cmd,
    output fsft_pkg::t_stat             o_stat,
    input  wire logic [63:0]            i_now,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [29:0]            i_cfg_data,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [fsft_pkg::OUT_W-1:0]  o_tdata
);
    import fsft_pkg::*;

    localparam int unsigned TW   = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned PW   = RAW_W + TW;
    localparam logic [TW-1:0] TPS = TW'(TICKS_PER_SECOND);
    localparam logic [24:0] SNAP = 25'(TICKS_PER_SECOND / 4000);

    logic              r_mode;
    logic [23:0]       r_target;
    logic [29:0]       r_freq;
    logic [26:0]       r_max;
    logic [63:0]       r_last;
    logic [63:0]       r_sacc;
    logic [31:0]       r_left;
    logic [23:0]       r_lstep;
    logic [63:0]       r_total;
    logic [31:0]       r_frames;
    logic [31:0]       r_fts;
    logic [31:0]       r_fps;
    logic              r_ovalid;
    logic [26:0]       r_raw;
    logic [PW-1:0]     r_prod;
    logic [31:0]       r_steps;
    logic [55:0]       r_inc;
    logic [171:0]      r_odata;

    logic [29:0]       n_freq;
    logic [63:0]       n_raw;
    logic [23:0]       n_scaled;
    logic [24:0]       n_diff;
    logic [24:0]       n_mag;
    logic [23:0]       n_snap;
    logic [32:0]       n_sum;
    logic [19:0]       n_upd;
    logic [63:0]       n_dvd;
    logic [31:0]       n_dvs;
    logic [6:0]        n_len;
    logic              div_done;
    logic [63:0]       div_quo;
    logic [31:0]       div_rem;

    always_comb begin
        n_freq   = (r_freq == 30'd0) ? 30'd1 : r_freq;
        n_raw    = i_now - r_last;
        n_scaled = (|div_quo[63:24]) ? 24'hFFFFFF : div_quo[23:0];
        n_diff   = {1'b0, n_scaled} - {1'b0, r_target};
        n_mag    = n_diff[24] ? 25'(-n_diff) : n_diff;
        n_snap   = (n_mag < SNAP) ? r_target : n_scaled;
        n_sum    = {1'b0, r_left} + {9'd0, n_snap};
        n_upd    = (|r_steps[31:20]) ? 20'hFFFFF : r_steps[19:0];
        unique case (i_cmd.div_sel)
            DIV_SCALE: begin
                n_dvd = 64'(r_prod);
                n_dvs = {2'b0, n_freq};
                n_len = 7'(PW);
            end
            DIV_STEP: begin
                n_dvd = {32'd0, r_left};
                n_dvs = {8'd0, r_target};
                n_len = 7'd32;
            end
            default: begin
                n_dvd = r_sacc;
                n_dvs = {2'b0, r_freq};
                n_len = 7'd64;
            end
        endcase
    end

    fsft_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .i_len      (n_len),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_target <= 24'd166666;
            r_freq   <= 30'd10000000;
            r_max    <= 27'd1000000;
            r_last   <= 64'd0;
            r_sacc   <= 64'd0;
            r_left   <= 32'd0;
            r_lstep  <= 24'd0;
            r_total  <= 64'd0;
            r_frames <= 32'd0;
            r_fts    <= 32'd0;
            r_fps    <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_TARGET: r_target <= i_cfg_data[23:0];
                    CFG_FREQ:   r_freq   <= i_cfg_data;
                    CFG_MAXRAW: r_max    <= i_cfg_data[26:0];
                endcase
            end
            if (r_ovalid && i_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_RESET: begin
                    r_last <= i_now;
                    r_left <= 32'd0;
                    r_fps  <= 32'd0;
                    r_fts  <= 32'd0;
                    r_sacc <= 64'd0;
                end
                OP_CAPTURE: begin
                    r_last <= i_now;
                    r_sacc <= r_sacc + n_raw;
                end
                OP_SCALE: begin
                    if (r_mode) begin
                        r_left <= n_sum[32] ? 32'hFFFFFFFF : n_sum[31:0];
                    end else begin
                        r_lstep  <= n_scaled;
                        r_total  <= r_total + {40'd0, n_scaled};
                        r_left   <= 32'd0;
                        r_frames <= r_frames + 32'd1;
                    end
                end
                OP_STEPS: begin
                    r_left <= div_rem;
                    if (div_quo[31:0] != 32'd0) begin
                        r_lstep <= r_target;
                    end
                end
                OP_TOTAL: begin
                    r_total  <= r_total + {8'd0, r_inc};
                    r_frames <= r_frames + r_steps;
                end
                OP_FRAME: begin
                    if (r_steps != 32'd0) begin
                        r_fts <= r_fts + 32'd1;
                    end
                end
                OP_CHECK: begin
                    if (r_freq == 30'd0) begin
                        r_fps  <= r_fts;
                        r_fts  <= 32'd0;
                        r_sacc <= 64'd0;
                    end else if (o_stat.sacc_ge) begin
                        r_fps <= r_fts;
                        r_fts <= 32'd0;
                    end
                end
                OP_SACC: r_sacc <= {32'd0, div_rem};
                OP_OUT:  r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_RESET: r_steps <= 32'd0;
            OP_CAPTURE: begin
                r_raw <= (n_raw > {37'd0, r_max}) ? r_max : n_raw[26:0];
            end
            OP_MUL: r_prod <= PW'(r_raw) * PW'(TPS);
            OP_SCALE: r_steps <= r_mode ? 32'd0 : 32'd1;
            OP_STEPS: begin
                r_steps <= div_quo[31:0];
                r_inc   <= 56'(div_quo[31:0]) * 56'(r_target);
            end
            OP_OUT: r_odata <= {r_fps, r_frames, r_total, r_lstep, n_upd};
            default: ;
        endcase
    end

    always_comb begin
        o_stat.div_done    = div_done;
        o_stat.fixed       = r_mode;
        o_stat.target_zero = (r_target == 24'd0);
        o_stat.freq_zero   = (r_freq == 30'd0);
        o_stat.sacc_ge     = (r_sacc >= {34'd0, r_freq});
        o_stat.out_busy    = r_ovalid && !i_tready;
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {4'd0, r_odata};

`include "fixed_step_frame_timer_unit_macros.svh"

    `FSFT_ASSERT(a_out_free, i_clk, i_rst_n, (i_cmd.op == OP_OUT) |-> !o_stat.out_busy)
    `FSFT_ASSERT(a_left_lt, i_clk, i_rst_n, (i_cmd.op == OP_STEPS) |=> (r_left < {8'd0, r_target}))
    `FSFT_ASSERT(a_free_one, i_clk, i_rst_n, (i_cmd.op == OP_SCALE && !r_mode) |=> (r_steps == 32'd1))
endmodule
`default_nettype wire

### rtl/fsft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fsft_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_req_reset,
    output logic                 o_in_ready,
    input  wire fsft_pkg::t_stat i_stat,
    output fsft_pkg::t_cmd       o_cmd
);
    import fsft_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_D1S, S_D1W, S_SCALE, S_D2S, S_D2W, S_STEPS,
        S_TOTAL, S_FRAME, S_CHECK, S_D3S, S_D3W, S_SACC, S_LOAD
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= i_req_reset ? S_LOAD : S_MUL;
                S_MUL:  r_state <= S_D1S;
                S_D1S:  r_state <= S_D1W;
                S_D1W:  if (i_stat.div_done) r_state <= S_SCALE;
                S_SCALE: begin
                    r_state <= (i_stat.fixed && !i_stat.target_zero) ? S_D2S : S_FRAME;
                end
                S_D2S:   r_state <= S_D2W;
                S_D2W:   if (i_stat.div_done) r_state <= S_STEPS;
                S_STEPS: r_state <= S_TOTAL;
                S_TOTAL: r_state <= S_FRAME;
                S_FRAME: r_state <= S_CHECK;
                S_CHECK: begin
                    r_state <= (!i_stat.freq_zero && i_stat.sacc_ge) ? S_D3S : S_LOAD;
                end
                S_D3S:  r_state <= S_D3W;
                S_D3W:  if (i_stat.div_done) r_state <= S_SACC;
                S_SACC: r_state <= S_LOAD;
                S_LOAD: if (!i_stat.out_busy) r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.op        = OP_NONE;
        o_cmd.div_start = 1'b0;
        o_cmd.div_sel   = DIV_SCALE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_cmd.op = i_req_reset ? OP_RESET : OP_CAPTURE;
            end
            S_MUL:   o_cmd.op = OP_MUL;
            S_D1S:   o_cmd.div_start = 1'b1;
            S_SCALE: o_cmd.op = OP_SCALE;
            S_D2S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STEP;
            end
            S_D2W:   o_cmd.div_sel = DIV_STEP;
            S_STEPS: o_cmd.op = OP_STEPS;
            S_TOTAL: o_cmd.op = OP_TOTAL;
            S_FRAME: o_cmd.op = OP_FRAME;
            S_CHECK: o_cmd.op = OP_CHECK;
            S_D3S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEC;
            end
            S_D3W:   o_cmd.div_sel = DIV_SEC;
            S_SACC:  o_cmd.op = OP_SACC;
            S_LOAD:  if (!i_stat.out_busy) o_cmd.op = OP_OUT;
            default: ;
        endcase
    end

`include "fixed_step_frame_timer_unit_macros.svh"

    `FSFT_ASSERT(a_start_clean, i_clk, i_rst_n, o_cmd.div_start |=> !i_stat.div_done)
    `FSFT_ASSERT(a_ready_cmd, i_clk, i_rst_n, (o_cmd.op == OP_CAPTURE) |-> o_in_ready)
    `FSFT_ASSERT(a_one_start, i_clk, i_rst_n, o_cmd.div_start |=> !o_cmd.div_start)
endmodule
`default_nettype wire

### rtl/fixed_step_frame_timer_unit.sv
// Fixed-step frame timer. One word in (a tick or a reset request with a raw counter reading)
// gives one word out. A reset request goes from acceptance straight to the load state, which
// registers its result once the output is free. A tick runs through a shared one-bit-per-cycle
// divider for the raw-to-tick scaling, for the fixed-step split (fixed mode, nonzero target
// only) and for the once-per-second wrap of the second accumulator (only once the accumulator
// reaches a nonzero frequency). One word is in work at a time. A finished result waits in the
// output register while the next word is accepted. Configuration writes are taken in any cycle,
// and their ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module fixed_step_frame_timer_unit #(
    parameter int unsigned TICKS_PER_SECOND = 10000000
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [63:0]           i_s_axis_tdata,  // counter_now
    input  wire logic                  i_s_axis_tuser,  // req_type
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // updates_run[19:0], elapsed_ticks[43:20], total_ticks[107:44],
    // frame_count[139:108], frames_per_second[171:140], zero pad
    output logic [fsft_pkg::OUT_W-1:0] o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [29:0]           i_cfg_data
);
    import fsft_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    fsft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_req_reset (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fsft_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_now       (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata)
    );
endmodule
`default_nettype wire
